>>> hw/rtl/qtl_pkg.sv
// qtl_pkg: shared types, token codes and character classes of the query token lexer.
// Depends on nothing; the other lexer files but qtl_fifo refer to it by scoped names.

package qtl_pkg;

	// default width of byte positions
	localparam int POS_WIDTH_DEF = 16;

	// queue depths
	localparam int IN_DEPTH  = 2;
	localparam int OUT_DEPTH = 4;

	// token kinds
	localparam logic [4:0] K_LPAREN  = 5'd0;
	localparam logic [4:0] K_RPAREN  = 5'd1;
	localparam logic [4:0] K_LBRACE  = 5'd2;
	localparam logic [4:0] K_RBRACE  = 5'd3;
	localparam logic [4:0] K_LBRACK  = 5'd4;
	localparam logic [4:0] K_RBRACK  = 5'd5;
	localparam logic [4:0] K_COMMA   = 5'd6;
	localparam logic [4:0] K_COLON   = 5'd7;
	localparam logic [4:0] K_STRING  = 5'd8;
	localparam logic [4:0] K_LE      = 5'd9;
	localparam logic [4:0] K_LT      = 5'd10;
	localparam logic [4:0] K_GE      = 5'd11;
	localparam logic [4:0] K_GT      = 5'd12;
	localparam logic [4:0] K_EQ      = 5'd13;
	localparam logic [4:0] K_TRUE    = 5'd14;
	localparam logic [4:0] K_FALSE   = 5'd15;
	localparam logic [4:0] K_IDENT   = 5'd16;
	localparam logic [4:0] K_INTEGER = 5'd17;
	localparam logic [4:0] K_FLOAT   = 5'd18;
	localparam logic [4:0] K_DOT     = 5'd19;
	localparam logic [4:0] K_END     = 5'd20;
	localparam logic [4:0] K_ERROR   = 5'd21;

	// keyword progress codes
	localparam logic [3:0] KW_NONE    = 4'd0;
	localparam logic [3:0] KW_T       = 4'd1;
	localparam logic [3:0] KW_TR      = 4'd2;
	localparam logic [3:0] KW_TRU     = 4'd3;
	localparam logic [3:0] KW_TRUE    = 4'd4;
	localparam logic [3:0] KW_F       = 4'd5;
	localparam logic [3:0] KW_FA      = 4'd6;
	localparam logic [3:0] KW_FAL     = 4'd7;
	localparam logic [3:0] KW_FALS    = 4'd8;
	localparam logic [3:0] KW_FALSE   = 4'd9;

	// character class of one byte
	typedef struct packed {
		logic dig;
		logic alpha;
		logic ws;
	} cls_t;

	// classified request as it travels through the input queue (position kept apart)
	typedef struct packed {
		logic       eot;
		logic [7:0] ch;
		cls_t       cls;
	} hdr_t;

	// one result token
	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} tok_t;

	function automatic cls_t classify(input logic [7:0] c);
		cls_t r;
		r.dig   = (c >= "0") && (c <= "9");
		r.alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
		r.ws    = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
		return r;
	endfunction

	// advance keyword match for "true" / "false"
	function automatic logic [3:0] kw_next(input logic [3:0] k, input logic [7:0] c);
		logic [3:0] r;
		r = KW_NONE;
		case (k)
			KW_T:    if (c == "r") r = KW_TR;
			KW_TR:   if (c == "u") r = KW_TRU;
			KW_TRU:  if (c == "e") r = KW_TRUE;
			KW_F:    if (c == "a") r = KW_FA;
			KW_FA:   if (c == "l") r = KW_FAL;
			KW_FAL:  if (c == "s") r = KW_FALS;
			KW_FALS: if (c == "e") r = KW_FALSE;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/query_token_lexer.sv
// query_token_lexer: streaming lexer, top level.
// Depends on qtl_pkg, qtl_fifo, qtl_front and qtl_back.
//
// Usage:
//   Input channel: a request (kind, character) is taken at a clock edge with push high and
//   full low. kind 0 carries a text byte, kind 1 the end-of-text mark.
//   Result channel: while empty is low, the oldest token is on token_code, token_start,
//   token_length and last_of_run; it is taken at an edge with pop high. last_of_run marks
//   the final token caused by one request.
//   Path: a request passes the input queue, the scanner and the token queue. A token closed
//   by a later byte is staged until it is known whether it is the last of its request; a
//   byte that ends an incomplete signed exponent gives its last token only after both held
//   bytes are replayed.
//   Throughput: one scan step per cycle in the back end while the token queue has room and
//   no final staged token waits. A byte that closes the open token is scanned again from
//   the idle state, and an incomplete float exponent rescans each held byte (one or two).
//   A two-entry input queue and a four-entry token queue decouple the sides: when the
//   receiver stalls, tokens collect in the token queue, then the scanner waits, then
//   full rises. Nothing is lost.
//   Reset (arst_n low) empties both queues and returns the scanner and the byte position
//   to the start of a text. No memory clearing pass is needed.

module query_token_lexer #(
	parameter int POSITION_WIDTH = qtl_pkg::POS_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  character,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  token_code,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        last_of_run
);

	localparam int IW = POSITION_WIDTH + $bits(qtl_pkg::hdr_t);
	localparam int TW = $bits(qtl_pkg::tok_t);

	logic          in_push, in_full, in_empty, in_pop;
	logic [IW-1:0] in_wdata, in_rdata;
	logic          out_push, out_full;
	qtl_pkg::tok_t out_tok, out_head;
	logic [TW-1:0] out_rdata;

	qtl_front #(.PW(POSITION_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.kind      (kind),
		.character (character),
		.full      (full),
		.q_full    (in_full),
		.q_push    (in_push),
		.q_data    (in_wdata)
	);

	qtl_fifo #(.W(IW), .D(qtl_pkg::IN_DEPTH)) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_push),
		.wdata  (in_wdata),
		.full   (in_full),
		.pop    (in_pop),
		.rdata  (in_rdata),
		.empty  (in_empty)
	);

	qtl_back #(.PW(POSITION_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!in_empty),
		.in_data  (in_rdata),
		.in_pop   (in_pop),
		.out_full (out_full),
		.out_push (out_push),
		.out_tok  (out_tok)
	);

	qtl_fifo #(.W(TW), .D(qtl_pkg::OUT_DEPTH)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_tok),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign out_head     = out_rdata;
	assign token_code   = out_head.kind;
	assign token_start  = out_head.start;
	assign token_length = out_head.len;
	assign last_of_run  = out_head.last;

`ifndef SYNTHESIS
	// the scanner never writes a token into a full token queue
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_push && out_full)) else $error("token written into full queue");

	// the scanner only takes requests that are present
	a_no_in_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_pop && in_empty)) else $error("request taken from empty queue");

	// a full input queue holds off the sender in the same cycle
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_full |-> !in_push) else $error("request written into full input queue");
`endif

endmodule

>>> hw/rtl/qtl_fifo.sv
// qtl_fifo: small register queue used between the lexer stages.
// Depends on nothing.

module qtl_fifo #(
	parameter int W = 8,
	parameter int D = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	logic [W-1:0]  mem_q [D];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(D));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(D - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(D - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/qtl_front.sv
// qtl_front: accepts requests, classifies the byte and stamps its position.
// Depends on qtl_pkg.

module qtl_front #(
	parameter int PW = qtl_pkg::POS_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              kind,
	input  logic [7:0]                        character,
	output logic                              full,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [PW+$bits(qtl_pkg::hdr_t)-1:0] q_data
);

	logic [PW-1:0]  pos_q;
	qtl_pkg::hdr_t  hdr;

	assign full   = q_full;
	assign q_push = push && !q_full;

	// classify; the end mark matches no class
	always_comb begin
		hdr.eot = kind;
		hdr.ch  = character;
		hdr.cls = kind ? '0 : qtl_pkg::classify(character);
	end

	assign q_data = {pos_q, hdr};

	// saturating byte position, back to zero after the end mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			if (kind) begin
				pos_q <= '0;
			end else if (pos_q != '1) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/qtl_back.sv
// qtl_back: lexer FSM; one step a cycle unless stalled; held-byte replay; token staging.
// Depends on qtl_pkg.

module qtl_back #(
	parameter int PW = qtl_pkg::POS_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [PW+$bits(qtl_pkg::hdr_t)-1:0] in_data,
	output logic                                in_pop,
	input  logic                                out_full,
	output logic                                out_push,
	output qtl_pkg::tok_t                       out_tok
);

	localparam int HB = $bits(qtl_pkg::hdr_t);
	localparam int EW = (PW > 16) ? PW : 17;

	typedef enum logic [15:0] {
		S_IDLE     = 16'h0001,
		S_LT       = 16'h0002,
		S_GT       = 16'h0004,
		S_STR      = 16'h0008,
		S_STR_ESC  = 16'h0010,
		S_IDENT    = 16'h0020,
		S_MINUS    = 16'h0040,
		S_PLUS     = 16'h0080,
		S_SIGN_DOT = 16'h0100,
		S_DOT      = 16'h0200,
		S_INT      = 16'h0400,
		S_MANT     = 16'h0800,
		S_FRAC     = 16'h1000,
		S_EXP_E    = 16'h2000,
		S_EXP_SIGN = 16'h4000,
		S_EXP_DIG  = 16'h8000
	} state_t;

	typedef enum logic [1:0] {
		RP_NONE = 2'd0,
		RP_H0   = 2'd1,
		RP_H1   = 2'd2
	} replay_t;

	function automatic logic [15:0] clamp16(input logic [PW-1:0] v);
		logic [EW-1:0] w;
		w = EW'(v);
		return (w > EW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic logic [PW-1:0] span(input logic [PW-1:0] b, input logic [PW-1:0] e);
		return (e >= b) ? e - b : '0;
	endfunction

	state_t        st_q, st_n;
	replay_t       rp_q, rp_n;
	logic [PW-1:0] tb_q, tb_n, ep_q, ep_n;
	logic [7:0]    h0_q, h0_n, h1_q, h1_n;
	logic [3:0]    kw_q, kw_n;
	logic          err_q, err_n, two_q, two_n;
	qtl_pkg::tok_t pend_q;
	logic          pend_v_q, pend_fin_q;

	qtl_pkg::hdr_t hdr;
	logic [PW-1:0] ipos;
	logic [7:0]    c;
	logic          eot;
	qtl_pkg::cls_t cls;
	logic [PW-1:0] p;

	logic          go, flush, emit, ret, fin;
	logic [4:0]    ekind;
	logic [PW-1:0] estart, elen;
	qtl_pkg::tok_t etok;

	assign hdr  = in_data[HB-1:0];
	assign ipos = in_data[PW+HB-1:HB];

	// current symbol: queue head or a replayed held byte
	always_comb begin
		case (rp_q)
			RP_H0: begin
				c = h0_q; eot = 1'b0; cls = qtl_pkg::classify(h0_q); p = ep_q;
			end
			RP_H1: begin
				c = h1_q; eot = 1'b0; cls = qtl_pkg::classify(h1_q); p = sat_inc(ep_q);
			end
			default: begin
				c = hdr.ch; eot = hdr.eot; cls = hdr.cls; p = ipos;
			end
		endcase
	end

	assign flush = pend_v_q && pend_fin_q && !out_full;
	assign go    = !out_full && !(pend_v_q && pend_fin_q) && ((rp_q != RP_NONE) || in_valid);

	// one scan step
	always_comb begin
		st_n = st_q; rp_n = rp_q; tb_n = tb_q; ep_n = ep_q;
		h0_n = h0_q; h1_n = h1_q; kw_n = kw_q; err_n = err_q; two_n = two_q;
		emit = 1'b0; ret = 1'b0;
		ekind = qtl_pkg::K_ERROR; estart = tb_q; elen = '0;
		if (rp_q == RP_NONE && err_q) begin
			ret = 1'b1;
		end else begin
			case (st_q)
				S_IDLE: begin
					tb_n   = p;
					estart = p;
					ret    = 1'b1;
					elen   = PW'(1);
					if (eot) begin
						emit = 1'b1; ekind = qtl_pkg::K_END; elen = '0;
					end else if (cls.ws) begin
						emit = 1'b0;
					end else if (cls.alpha) begin
						kw_n = (c == "t") ? qtl_pkg::KW_T :
							((c == "f") ? qtl_pkg::KW_F : qtl_pkg::KW_NONE);
						st_n = S_IDENT;
					end else if (cls.dig) begin
						st_n = S_INT;
					end else begin
						case (c)
							"(": begin emit = 1'b1; ekind = qtl_pkg::K_LPAREN; end
							")": begin emit = 1'b1; ekind = qtl_pkg::K_RPAREN; end
							"{": begin emit = 1'b1; ekind = qtl_pkg::K_LBRACE; end
							"}": begin emit = 1'b1; ekind = qtl_pkg::K_RBRACE; end
							"[": begin emit = 1'b1; ekind = qtl_pkg::K_LBRACK; end
							"]": begin emit = 1'b1; ekind = qtl_pkg::K_RBRACK; end
							",": begin emit = 1'b1; ekind = qtl_pkg::K_COMMA; end
							":": begin emit = 1'b1; ekind = qtl_pkg::K_COLON; end
							"=": begin emit = 1'b1; ekind = qtl_pkg::K_EQ; end
							"\"": st_n = S_STR;
							"<": st_n = S_LT;
							">": st_n = S_GT;
							"-": st_n = S_MINUS;
							"+": st_n = S_PLUS;
							".": st_n = S_DOT;
							default: begin
								emit = 1'b1; ekind = qtl_pkg::K_ERROR; elen = '0;
								err_n = 1'b1;
							end
						endcase
					end
				end
				S_LT, S_GT: begin
					emit = 1'b1;
					st_n = S_IDLE;
					if (!eot && c == "=") begin
						ekind = (st_q == S_LT) ? qtl_pkg::K_LE : qtl_pkg::K_GE;
						elen  = span(tb_q, sat_inc(p));
						ret   = 1'b1;
					end else begin
						ekind = (st_q == S_LT) ? qtl_pkg::K_LT : qtl_pkg::K_GT;
						elen  = span(tb_q, p);
					end
				end
				S_STR: begin
					ret = 1'b1;
					if (eot) begin
						emit = 1'b1; err_n = 1'b1; st_n = S_IDLE;
					end else if (c == "\\") begin
						st_n = S_STR_ESC;
					end else if (c == "\"") begin
						emit = 1'b1; ekind = qtl_pkg::K_STRING;
						elen = span(tb_q, sat_inc(p)); st_n = S_IDLE;
					end
				end
				S_STR_ESC: begin
					ret = 1'b1;
					if (eot || c == 8'h0A || c == 8'h0D) begin
						emit = 1'b1; err_n = 1'b1; st_n = S_IDLE;
					end else begin
						st_n = S_STR;
					end
				end
				S_IDENT: begin
					if (cls.alpha || cls.dig) begin
						kw_n = qtl_pkg::kw_next(kw_q, c);
						ret  = 1'b1;
					end else begin
						emit  = 1'b1;
						ekind = (kw_q == qtl_pkg::KW_TRUE) ? qtl_pkg::K_TRUE :
							((kw_q == qtl_pkg::KW_FALSE) ? qtl_pkg::K_FALSE : qtl_pkg::K_IDENT);
						elen  = span(tb_q, p);
						st_n  = S_IDLE;
					end
				end
				S_MINUS, S_PLUS: begin
					ret = 1'b1;
					if (cls.dig) begin
						st_n = (st_q == S_MINUS) ? S_INT : S_MANT;
					end else if (!eot && c == ".") begin
						st_n = S_SIGN_DOT;
					end else begin
						emit = 1'b1; err_n = 1'b1; st_n = S_IDLE;
					end
				end
				S_SIGN_DOT: begin
					ret = 1'b1;
					if (cls.dig) begin
						st_n = S_FRAC;
					end else begin
						emit = 1'b1; err_n = 1'b1; st_n = S_IDLE;
					end
				end
				S_DOT: begin
					if (cls.dig) begin
						ret = 1'b1; st_n = S_FRAC;
					end else begin
						emit = 1'b1; ekind = qtl_pkg::K_DOT; elen = span(tb_q, p); st_n = S_IDLE;
					end
				end
				S_INT: begin
					if (cls.dig) begin
						ret = 1'b1;
					end else if (!eot && c == ".") begin
						ret = 1'b1; st_n = S_FRAC;
					end else begin
						emit = 1'b1; ekind = qtl_pkg::K_INTEGER; elen = span(tb_q, p);
						st_n = S_IDLE;
					end
				end
				S_MANT, S_FRAC: begin
					if (cls.dig) begin
						ret = 1'b1;
					end else if (!eot && c == "." && st_q == S_MANT) begin
						ret = 1'b1; st_n = S_FRAC;
					end else if (!eot && (c == "e" || c == "E")) begin
						ret = 1'b1; h0_n = c; ep_n = p; st_n = S_EXP_E;
					end else begin
						emit = 1'b1; ekind = qtl_pkg::K_FLOAT; elen = span(tb_q, p);
						st_n = S_IDLE;
					end
				end
				S_EXP_E, S_EXP_SIGN: begin
					if (cls.dig) begin
						ret = 1'b1; st_n = S_EXP_DIG;
					end else if (st_q == S_EXP_E && !eot && (c == "+" || c == "-")) begin
						ret = 1'b1; h1_n = c; st_n = S_EXP_SIGN;
					end else begin
						// incomplete exponent: close the float before the letter, replay held bytes
						emit  = 1'b1; ekind = qtl_pkg::K_FLOAT; elen = span(tb_q, ep_q);
						st_n  = S_IDLE;
						rp_n  = RP_H0;
						two_n = (st_q == S_EXP_SIGN);
					end
				end
				S_EXP_DIG: begin
					if (cls.dig) begin
						ret = 1'b1;
					end else begin
						emit = 1'b1; ekind = qtl_pkg::K_FLOAT; elen = span(tb_q, p);
						st_n = S_IDLE;
					end
				end
				default: begin
					st_n = S_IDLE;
				end
			endcase
		end
		// replay bookkeeping
		if (ret) begin
			case (rp_q)
				RP_H0:   rp_n = two_q ? RP_H1 : RP_NONE;
				RP_H1:   rp_n = RP_NONE;
				default: rp_n = RP_NONE;
			endcase
		end
		// end mark returns state, keyword and error flags to reset values, positions to zero
		if (ret && rp_q == RP_NONE && eot) begin
			st_n = S_IDLE; tb_n = '0; ep_n = '0; kw_n = qtl_pkg::KW_NONE;
			err_n = 1'b0; two_n = 1'b0;
		end
	end

	// the request itself is used up; a replayed held byte is not
	assign fin = ret && (rp_q == RP_NONE);

	always_comb begin
		etok.kind  = ekind;
		etok.start = clamp16(estart);
		etok.len   = clamp16(elen);
		etok.last  = 1'b0;
	end

	// token staging: the newest token waits until it is known whether it is the last one
	always_comb begin
		out_push = 1'b0;
		out_tok  = pend_q;
		if (flush) begin
			out_push     = 1'b1;
			out_tok.last = 1'b1;
		end else if (go) begin
			if (emit) begin
				if (pend_v_q) begin
					out_push = 1'b1;
				end else if (fin) begin
					out_push     = 1'b1;
					out_tok      = etok;
					out_tok.last = 1'b1;
				end
			end else if (fin && pend_v_q) begin
				out_push     = 1'b1;
				out_tok.last = 1'b1;
			end
		end
	end

	assign in_pop = go && fin;

	// payload registers
	always_ff @(posedge clk) begin
		if (go) begin
			tb_q <= tb_n; ep_q <= ep_n; h0_q <= h0_n; h1_q <= h1_n;
		end
		if (go && emit) begin
			pend_q <= etok;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			rp_q       <= RP_NONE;
			kw_q       <= qtl_pkg::KW_NONE;
			err_q      <= 1'b0;
			two_q      <= 1'b0;
			pend_v_q   <= 1'b0;
			pend_fin_q <= 1'b0;
		end else if (flush) begin
			pend_v_q   <= 1'b0;
			pend_fin_q <= 1'b0;
		end else if (go) begin
			st_q  <= st_n;
			rp_q  <= rp_n;
			kw_q  <= kw_n;
			err_q <= err_n;
			two_q <= two_n;
			if (emit) begin
				if (pend_v_q || !fin) begin
					pend_v_q   <= 1'b1;
					pend_fin_q <= fin;
				end
			end else if (fin) begin
				pend_v_q   <= 1'b0;
				pend_fin_q <= 1'b0;
			end
		end
	end

endmodule

>>> bench/qtl_checker.sv
// qtl_checker: watches both queue ports of query_token_lexer, predicts the token stream
// and compares every popped token field by field. Depends on qtl_pkg (token codes, tok_t).
`timescale 1ns / 100ps

module qtl_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        kind,
	input  logic [7:0]  character,
	input  logic        empty,
	input  logic        pop,
	input  logic [4:0]  token_code,
	input  logic [15:0] token_start,
	input  logic [15:0] token_length,
	input  logic        last_of_run,
	output int          errors,
	output int          pending,
	output int          tokens_seen
);

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	typedef enum logic [3:0] {
		SC_IDLE, SC_LT, SC_GT, SC_STR, SC_STR_ESC, SC_IDENT, SC_MINUS, SC_PLUS,
		SC_SIGN_DOT, SC_DOT, SC_INT, SC_MANT, SC_FRAC, SC_EXP_E, SC_EXP_SIGN, SC_EXP_DIG
	} scan_t;

	// predicted lexer state
	scan_t       sc;
	logic [15:0] pos_cnt, tok_begin, exp_at;
	logic [7:0]  held0, held1;
	int          held_n;
	logic [3:0]  kw;
	bit          err_seen;
	int          step_toks;

	qtl_pkg::tok_t expected_tokens[$];

	function automatic logic [15:0] sat_inc(logic [15:0] p);
		return (p < POS_MAX) ? p + 16'd1 : p;
	endfunction

	function automatic void clear_scan();
		sc = SC_IDLE;
		pos_cnt = '0;
		tok_begin = '0;
		held0 = '0;
		held1 = '0;
		held_n = 0;
		kw = qtl_pkg::KW_NONE;
		err_seen = 0;
		exp_at = '0;
	endfunction

	function automatic void add_token(logic [4:0] k, logic [15:0] st, logic [15:0] ln);
		qtl_pkg::tok_t t;
		if (step_toks >= 4)
			return;
		t.kind = k;
		t.start = st;
		t.len = ln;
		t.last = 1'b0;
		expected_tokens.push_back(t);
		step_toks++;
	endfunction

	function automatic void close_token(logic [4:0] k, logic [15:0] endp);
		add_token(k, tok_begin, (endp >= tok_begin) ? endp - tok_begin : 16'd0);
		sc = SC_IDLE;
	endfunction

	function automatic void lex_error();
		add_token(qtl_pkg::K_ERROR, tok_begin, 16'd0);
		err_seen = 1;
		sc = SC_IDLE;
		held_n = 0;
	endfunction

	function automatic bit is_dig(int c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(int c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	// one byte (c >= 0) or end mark (c < 0) at position p
	function automatic void scan_byte(int c, logic [15:0] p);
		logic [7:0]  h0, h1;
		int          n;
		logic [15:0] ep;
		while (1) begin
			if (err_seen)
				return;
			case (sc)
				SC_IDLE: begin
					tok_begin = p;
					if (c < 0) begin
						add_token(qtl_pkg::K_END, p, 16'd0);
						return;
					end
					if (c == " " || c == 9 || c == 13 || c == 10)
						return;
					case (c)
						"(": begin add_token(qtl_pkg::K_LPAREN, p, 16'd1); return; end
						")": begin add_token(qtl_pkg::K_RPAREN, p, 16'd1); return; end
						"{": begin add_token(qtl_pkg::K_LBRACE, p, 16'd1); return; end
						"}": begin add_token(qtl_pkg::K_RBRACE, p, 16'd1); return; end
						"[": begin add_token(qtl_pkg::K_LBRACK, p, 16'd1); return; end
						"]": begin add_token(qtl_pkg::K_RBRACK, p, 16'd1); return; end
						",": begin add_token(qtl_pkg::K_COMMA, p, 16'd1); return; end
						":": begin add_token(qtl_pkg::K_COLON, p, 16'd1); return; end
						"=": begin add_token(qtl_pkg::K_EQ, p, 16'd1); return; end
						"\"": begin sc = SC_STR; return; end
						"<": begin sc = SC_LT; return; end
						">": begin sc = SC_GT; return; end
						"-": begin sc = SC_MINUS; return; end
						"+": begin sc = SC_PLUS; return; end
						".": begin sc = SC_DOT; return; end
						default: ;
					endcase
					if (is_alpha(c)) begin
						kw = (c == "t") ? qtl_pkg::KW_T :
							((c == "f") ? qtl_pkg::KW_F : qtl_pkg::KW_NONE);
						sc = SC_IDENT;
						return;
					end
					if (is_dig(c)) begin
						sc = SC_INT;
						return;
					end
					lex_error();
					return;
				end
				SC_LT, SC_GT: begin
					if (c == "=") begin
						close_token((sc == SC_LT) ? qtl_pkg::K_LE : qtl_pkg::K_GE, sat_inc(p));
						return;
					end
					close_token((sc == SC_LT) ? qtl_pkg::K_LT : qtl_pkg::K_GT, p);
				end
				SC_STR: begin
					if (c < 0) begin
						lex_error();
						return;
					end
					if (c == "\\")
						sc = SC_STR_ESC;
					else if (c == "\"")
						close_token(qtl_pkg::K_STRING, sat_inc(p));
					return;
				end
				SC_STR_ESC: begin
					if (c < 0 || c == 10 || c == 13) begin
						lex_error();
						return;
					end
					sc = SC_STR;
					return;
				end
				SC_IDENT: begin
					if (is_alpha(c) || is_dig(c)) begin
						kw = (c >= 0) ? qtl_pkg::kw_next(kw, 8'(c)) : qtl_pkg::KW_NONE;
						return;
					end
					close_token((kw == qtl_pkg::KW_TRUE) ? qtl_pkg::K_TRUE :
						((kw == qtl_pkg::KW_FALSE) ? qtl_pkg::K_FALSE : qtl_pkg::K_IDENT), p);
				end
				SC_MINUS, SC_PLUS: begin
					if (is_dig(c))
						sc = (sc == SC_MINUS) ? SC_INT : SC_MANT;
					else if (c == ".")
						sc = SC_SIGN_DOT;
					else
						lex_error();
					return;
				end
				SC_SIGN_DOT: begin
					if (is_dig(c))
						sc = SC_FRAC;
					else
						lex_error();
					return;
				end
				SC_DOT: begin
					if (is_dig(c)) begin
						sc = SC_FRAC;
						return;
					end
					close_token(qtl_pkg::K_DOT, p);
				end
				SC_INT: begin
					if (is_dig(c))
						return;
					if (c == ".") begin
						sc = SC_FRAC;
						return;
					end
					close_token(qtl_pkg::K_INTEGER, p);
				end
				SC_MANT, SC_FRAC: begin
					if (is_dig(c))
						return;
					if (c == "." && sc == SC_MANT) begin
						sc = SC_FRAC;
						return;
					end
					if (c == "e" || c == "E") begin
						held0 = 8'(c);
						held_n = 1;
						exp_at = p;
						sc = SC_EXP_E;
						return;
					end
					close_token(qtl_pkg::K_FLOAT, p);
				end
				SC_EXP_E, SC_EXP_SIGN: begin
					if (is_dig(c)) begin
						held_n = 0;
						sc = SC_EXP_DIG;
						return;
					end
					if (sc == SC_EXP_E && (c == "+" || c == "-")) begin
						held1 = 8'(c);
						held_n = 2;
						sc = SC_EXP_SIGN;
						return;
					end
					// incomplete exponent: float ends before the e, held bytes rescanned
					h0 = held0;
					h1 = held1;
					n = held_n;
					ep = exp_at;
					close_token(qtl_pkg::K_FLOAT, ep);
					held_n = 0;
					scan_byte(h0, ep);
					if (n > 1)
						scan_byte(h1, sat_inc(ep));
				end
				SC_EXP_DIG: begin
					if (is_dig(c))
						return;
					close_token(qtl_pkg::K_FLOAT, p);
				end
				default: sc = SC_IDLE;
			endcase
		end
	endfunction

	// compare popped token with oldest expectation, then predict from accepted request
	always @(posedge clk or negedge arst_n) begin : watch
		qtl_pkg::tok_t e;
		int            first;
		if (!arst_n) begin
			clear_scan();
			expected_tokens.delete();
			errors <= 0;
			pending <= 0;
			tokens_seen <= 0;
		end else begin
			if (pop && !empty) begin
				tokens_seen <= tokens_seen + 1;
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected token kind=%0d start=%0d len=%0d last=%0b",
						$time, token_code, token_start, token_length, last_of_run);
					errors <= errors + 1;
				end else begin
					e = expected_tokens.pop_front();
					if (e.kind !== token_code || e.start !== token_start ||
							e.len !== token_length || e.last !== last_of_run) begin
						$display({"%0t: token mismatch expected kind=%0d start=%0d len=%0d ",
							"last=%0b, actual kind=%0d start=%0d len=%0d last=%0b"},
							$time, e.kind, e.start, e.len, e.last,
							token_code, token_start, token_length, last_of_run);
						errors <= errors + 1;
					end
				end
			end
			if (push && !full) begin
				step_toks = 0;
				first = expected_tokens.size();
				if (kind) begin
					scan_byte(-1, pos_cnt);
					clear_scan();
				end else begin
					scan_byte(int'(character), pos_cnt);
					pos_cnt = sat_inc(pos_cnt);
				end
				if (expected_tokens.size() > first)
					expected_tokens[expected_tokens.size() - 1].last = 1'b1;
			end
			pending <= expected_tokens.size();
		end
	end

endmodule

>>> bench/tb_top.sv
// tb_top: stimulus and verdict for query_token_lexer; random texts of query tokens,
// noise and end marks. Depends on qtl_pkg, the lexer RTL and qtl_checker.
`timescale 1ns / 100ps

module tb_top;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        kind = 0;
	logic [7:0]  character = '0;
	logic        pop = 0;
	logic        full, empty, last_of_run;
	logic [4:0]  token_code;
	logic [15:0] token_start, token_length;
	int          errors, pending, tokens_seen;

	bit          no_gap_send = 0;
	bit          no_gap_recv = 0;
	bit          hold_recv = 0;
	int          sent = 0;
	int          texts = 0;
	longint      cycles = 0;
	logic [7:0]  txt[$];

	always #2 clk = ~clk;

	query_token_lexer DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.character(character), .empty(empty), .pop(pop), .token_code(token_code),
		.token_start(token_start), .token_length(token_length), .last_of_run(last_of_run)
	);

	qtl_checker u_chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.character(character), .empty(empty), .pop(pop), .token_code(token_code),
		.token_start(token_start), .token_length(token_length), .last_of_run(last_of_run),
		.errors(errors), .pending(pending), .tokens_seen(tokens_seen)
	);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// result side: random pop gaps, plus one long hold-off on request
	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_recv) begin
				pop <= 0;
				repeat (80) @(posedge clk);
				hold_recv = 0;
			end
			n = no_gap_recv ? 0 : $urandom_range(0, 10);
			if (n > 0) begin
				pop <= 0;
				repeat (n) @(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	// one request, waits until taken
	task automatic send_req(logic k, logic [7:0] c);
		int n;
		n = no_gap_send ? 0 : $urandom_range(0, 10);
		if (n > 0) begin
			push <= 0;
			repeat (n) @(posedge clk);
		end
		push <= 1;
		kind <= k;
		character <= c;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
	endtask

	task automatic add_digits(int lo);
		int n;
		n = $urandom_range(lo, 4);
		repeat (n) txt.push_back(8'("0" + $urandom_range(0, 9)));
	endtask

	// sends the queued text, then an end mark with a random byte
	task automatic flush_text();
		while (txt.size() > 0)
			send_req(1'b0, txt.pop_front());
		send_req(1'b1, 8'($urandom_range(0, 255)));
		texts++;
	endtask

	// one random token-like fragment
	task automatic add_fragment();
		string punct;
		int    n;
		punct = "(){}[],:=<>.";
		case ($urandom_range(0, 11))
			0: txt.push_back(punct[$urandom_range(0, punct.len() - 1)]);
			1: add_str($urandom_range(0, 1) ? "<=" : ">=");
			2: begin
				txt.push_back("\"");
				n = $urandom_range(0, 5);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) begin
						txt.push_back("\\");
						case ($urandom_range(0, 5))
							0: txt.push_back(8'h0A);
							1: txt.push_back(8'h0D);
							default: txt.push_back(8'($urandom_range(32, 126)));
						endcase
					end else
						txt.push_back(8'($urandom_range(32, 126)));
				end
				if ($urandom_range(0, 7) != 0)
					txt.push_back("\"");
			end
			3: case ($urandom_range(0, 5))
				0: add_str("true");
				1: add_str("false");
				2: add_str("tru");
				3: add_str("falsey");
				4: add_str("true_1");
				default: add_str("fals");
			endcase
			4: begin
				txt.push_back($urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : "_");
				n = $urandom_range(0, 5);
				repeat (n) case ($urandom_range(0, 3))
					0: txt.push_back(8'("0" + $urandom_range(0, 9)));
					1: txt.push_back(8'("A" + $urandom_range(0, 25)));
					2: txt.push_back("_");
					default: txt.push_back(8'("a" + $urandom_range(0, 25)));
				endcase
			end
			5: begin
				if ($urandom_range(0, 1))
					txt.push_back("-");
				add_digits(1);
			end
			6: begin
				case ($urandom_range(0, 3))
					0: txt.push_back("+");
					1: txt.push_back("-");
					default: ;
				endcase
				add_digits(0);
				txt.push_back(".");
				add_digits(0);
				if ($urandom_range(0, 1)) begin
					txt.push_back($urandom_range(0, 1) ? "e" : "E");
					case ($urandom_range(0, 2))
						0: txt.push_back("+");
						1: txt.push_back("-");
						default: ;
					endcase
					add_digits(0);
				end
			end
			7: begin
				add_digits(1);
				txt.push_back("e");
				add_digits(0);
			end
			8: txt.push_back(8'(($urandom_range(0, 3) == 0) ? 8'h09 : 8'h0A));
			9: txt.push_back(8'($urandom_range(0, 255)));
			default: txt.push_back(" ");
		endcase
		if ($urandom_range(0, 2) == 0)
			txt.push_back(" ");
	endtask

	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin : stimulus
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed texts: every token kind, exponent backtrack, error cases
		add_str("(){}[],:=<<=>>= \"a\\\"b\" true false x_9 -12 .5 1.5e+3 1.5e 2.e- 5e3 . +");
		flush_text();
		add_str("1 @ 2");
		flush_text();
		add_str("\"open");
		flush_text();
		add_str("\"a\\");
		txt.push_back(8'h0A);
		flush_text();
		add_str("-");
		flush_text();
		flush_text();
		drain();

		// receiver holds off while a dense text arrives back to back
		no_gap_send = 1;
		hold_recv = 1;
		repeat (30) add_str("(");
		flush_text();
		no_gap_send = 0;
		drain();

		// random texts
		while (sent < 380) begin
			no_gap_send = ($urandom_range(0, 5) == 0);
			no_gap_recv = ($urandom_range(0, 5) == 0);
			n = $urandom_range(1, 12);
			repeat (n) add_fragment();
			flush_text();
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		no_gap_recv = 0;
		drain();

		$display("%0d requests in %0d texts, %0d tokens checked, with stalls and backtracking",
			sent, texts, tokens_seen);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
